// ===== rtl/core/led_matrix_scan_framebuffer_top_defines.svh =====
// Assertion macros used by the LED matrix scan controller port checker.
`ifndef LED_MATRIX_SCAN_FRAMEBUFFER_TOP_DEFINES_SVH
`define LED_MATRIX_SCAN_FRAMEBUFFER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LMSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LMSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lmsf_pkg.sv =====
// Package with field widths, item codes and constants of the LED matrix scan controller.
package lmsf_pkg;

    localparam int KIND_W      = 3;
    localparam int ROW_IN_W    = 4;
    localparam int COL_IN_W    = 5;
    localparam int ROW_MASK_W  = 20;
    localparam int PORT_W      = 40;
    localparam int OUT_ROW_W   = 4;
    localparam int DUTY_W      = 8;
    localparam int PCT_W       = 7;

    // Item codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ROW   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FILL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SCAN  = 3'd4;

    // Brightness to duty: duty = 255 * (100 - pct) / 100, with the divide by 100
    // done as a multiply by ceil(2^19 / 100) and a shift; exact for inputs below 25500.
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam int               SCALED_W    = 15;
    localparam int               RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 13'd5243;
    localparam int               DIV100_SHIFT = 19;
    localparam int               PROD_W      = SCALED_W + RECIP_W;

endpackage

// ===== rtl/core/led_matrix_scan_framebuffer_top.sv =====
// Top level of the multiplexed LED matrix row-scan controller with its frame store.
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ---------------------------------------------
//  in        in_valid / in_ready        kind, row_index, column_index, pixel_on,
//                                       row_mask
//  out       out_valid / out_ready      port_word, is_blank, scanned_row,
//                                       oe_high_duty, last
//  cfg       cfg_write_en (no wait)     cfg_write_data (brightness percent)
//
// A frame update item changes the frame store at the edge of its transfer.
// A scan item loads the result register with its pair of port words, which leave one per cycle
// while out_ready is high; the single result register holds one pair, so the next item is taken
// in the cycle in which the previous row word leaves.
// Reset clears the frame store and scan row, empties the result register and sets brightness
// to 100 percent. A stall on out only holds back items, never drops or repeats a word.
module led_matrix_scan_framebuffer_top #(
    parameter int ROWS = 12,
    parameter int COLS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lmsf_pkg::KIND_W-1:0]       kind,
    input  logic [lmsf_pkg::ROW_IN_W-1:0]     row_index,
    input  logic [lmsf_pkg::COL_IN_W-1:0]     column_index,
    input  logic                              pixel_on,
    input  logic [lmsf_pkg::ROW_MASK_W-1:0]   row_mask,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lmsf_pkg::PORT_W-1:0]       port_word,
    output logic                              is_blank,
    output logic [lmsf_pkg::OUT_ROW_W-1:0]    scanned_row,
    output logic [lmsf_pkg::DUTY_W-1:0]       oe_high_duty,
    output logic                              last,

    input  logic                              cfg_write_en,
    input  logic [lmsf_pkg::PCT_W-1:0]        cfg_write_data
);
    import lmsf_pkg::*;

    localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MASK_EXT_W = (COLS > ROW_MASK_W) ? COLS : ROW_MASK_W;
    // Blank word: every row line high (off), every column low.
    localparam logic [PORT_W-1:0] BLANK_WORD = PORT_W'((64'd1 << ROWS) - 64'd1);

    // Frame store: one register row per matrix row, so clear and fill update every row at once.
    logic [COLS-1:0]      frame_reg  [ROWS];
    logic [COLS-1:0]      frame_next [ROWS];
    logic [ROW_IDX_W-1:0] scan_row_reg, scan_row_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;

    // Result register holding one scan pair; phase selects blank or row word.
    logic                 buf_valid_reg, buf_valid_next;
    logic                 phase_reg, phase_next;
    logic [PORT_W-1:0]    row_word_reg, row_word_next;
    logic [ROW_IDX_W-1:0] pair_row_reg, pair_row_next;
    logic [DUTY_W-1:0]    pair_duty_reg, pair_duty_next;

    logic                 in_xfer;
    logic                 out_xfer;
    logic                 is_scan;
    logic [COLS-1:0]      mask_cols;
    logic [MASK_EXT_W-1:0] mask_ext;
    logic [PORT_W-1:0]    scan_word;

    logic [PCT_W-1:0]     pct_clamped;
    logic [PCT_W-1:0]     pct_dark;
    logic [SCALED_W-1:0]  duty_scaled;
    logic [PROD_W-1:0]    duty_prod;

    // A new item enters when the result register is empty or its row word leaves now.
    assign in_ready = !buf_valid_reg || (out_ready && phase_reg);
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = buf_valid_reg && out_ready;
    assign is_scan  = (kind == KIND_SCAN);

    assign mask_ext  = MASK_EXT_W'(row_mask);
    assign mask_cols = mask_ext[COLS-1:0];

    // Frame store update for the non-scan item kinds. Out-of-range rows or columns
    // match no register row or bit and so leave the store unchanged.
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            frame_next[r] = frame_reg[r];
            if (in_xfer)
            begin
                case (kind)
                    KIND_CLEAR:
                    begin
                        frame_next[r] = '0;
                    end
                    KIND_PIXEL:
                    begin
                        if ({1'b0, row_index} == 5'(r))
                        begin
                            for (int c = 0; c < COLS; c++)
                            begin
                                if (column_index == COL_IN_W'(c))
                                begin
                                    frame_next[r][c] = pixel_on;
                                end
                            end
                        end
                    end
                    KIND_ROW:
                    begin
                        if ({1'b0, row_index} == 5'(r))
                        begin
                            frame_next[r] = mask_cols;
                        end
                    end
                    KIND_FILL:
                    begin
                        frame_next[r] = pixel_on ? '1 : '0;
                    end
                    default:
                    begin
                        frame_next[r] = frame_reg[r];
                    end
                endcase
            end
        end
    end

    lmsf_word_gen #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .ROW_IDX_W (ROW_IDX_W)
    ) u_word_gen (
        .row_sel (scan_row_reg),
        .cols    (frame_reg[scan_row_reg]),
        .word    (scan_word)
    );

    // Brightness register is kept as the output-enable duty it implies; values above
    // 100 percent count as 100.
    always_comb
    begin
        pct_clamped = (cfg_write_data > PCT_MAX) ? PCT_MAX : cfg_write_data;
        pct_dark    = PCT_MAX - pct_clamped;
        duty_scaled = (SCALED_W'(pct_dark) << 8) - SCALED_W'(pct_dark);
        duty_prod   = PROD_W'(duty_scaled) * PROD_W'(DIV100_RECIP);
        duty_next   = cfg_write_en ? DUTY_W'(duty_prod >> DIV100_SHIFT) : duty_reg;
    end

    // Scan pair sequencing: load on a scan item, then blank word, then row word.
    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        phase_next     = phase_reg;
        row_word_next  = row_word_reg;
        pair_row_next  = pair_row_reg;
        pair_duty_next = pair_duty_reg;
        scan_row_next  = scan_row_reg;
        if (in_xfer && is_scan)
        begin
            buf_valid_next = 1'b1;
            phase_next     = 1'b0;
            row_word_next  = scan_word;
            pair_row_next  = scan_row_reg;
            pair_duty_next = duty_reg;
            scan_row_next  = (scan_row_reg == ROW_IDX_W'(ROWS - 1)) ? '0
                                                                    : scan_row_reg + 1'b1;
        end
        else if (out_xfer)
        begin
            if (phase_reg)
            begin
                buf_valid_next = 1'b0;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_reg[r] <= '0;
            end
            scan_row_reg  <= '0;
            duty_reg      <= '0;
            buf_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_reg[r] <= frame_next[r];
            end
            scan_row_reg  <= scan_row_next;
            duty_reg      <= duty_next;
            buf_valid_reg <= buf_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_word_reg  <= row_word_next;
        pair_row_reg  <= pair_row_next;
        pair_duty_reg <= pair_duty_next;
    end

    assign out_valid    = buf_valid_reg;
    assign port_word    = phase_reg ? row_word_reg : BLANK_WORD;
    assign is_blank     = !phase_reg;
    assign last         = phase_reg;
    assign scanned_row  = OUT_ROW_W'(pair_row_reg);
    assign oe_high_duty = pair_duty_reg;

endmodule

// ===== rtl/core/lmsf_word_gen.sv =====
// Expander port word builder: active-low row select and reversed column bits.
module lmsf_word_gen #(
    parameter int ROWS      = 12,
    parameter int COLS      = 20,
    parameter int ROW_IDX_W = 4
) (
    input  logic [ROW_IDX_W-1:0]      row_sel,
    input  logic [COLS-1:0]           cols,
    output logic [lmsf_pkg::PORT_W-1:0] word
);
    import lmsf_pkg::*;

    // Row bits sit at the bottom, columns follow with column 0 at the top;
    // anything past the port width is dropped.
    for (genvar b = 0; b < PORT_W; b++) begin : g_bit
        if (b < ROWS) begin : g_row
            assign word[b] = (row_sel != ROW_IDX_W'(b));
        end else if (b < ROWS + COLS) begin : g_col
            assign word[b] = cols[ROWS + COLS - 1 - b];
        end else begin : g_pad
            assign word[b] = 1'b0;
        end
    end

endmodule

// ===== rtl/core/lmsf_port_checker.sv =====
// Port-level checker for the LED matrix scan controller, bound to the top level.
`include "led_matrix_scan_framebuffer_top_defines.svh"

module lmsf_port_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [lmsf_pkg::PORT_W-1:0]       port_word,
    input logic                              is_blank,
    input logic [lmsf_pkg::OUT_ROW_W-1:0]    scanned_row,
    input logic [lmsf_pkg::DUTY_W-1:0]       oe_high_duty,
    input logic                              last
);
    import lmsf_pkg::*;

    // A stalled output word holds its value.
    `LMSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(port_word) && $stable(last), "output word changed while stalled")

    // The row word follows its blank word directly.
    `LMSF_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && is_blank,
        out_valid && !is_blank && last, "blank word not followed by row word")

    // Both words of a pair name the same row and duty.
    `LMSF_ASSERT_NEXT(a_pair_same, out_valid && out_ready && is_blank,
        scanned_row == $past(scanned_row) && oe_high_duty == $past(oe_high_duty),
        "scan pair words disagree")

    // New items are only taken while no word is pending, or as the row word leaves.
    `LMSF_ASSERT_NOW(a_ready_gap, out_valid && in_ready, last && out_ready,
        "input taken while a scan pair is still pending")

endmodule

bind led_matrix_scan_framebuffer_top lmsf_port_checker u_lmsf_port_checker (.*);
